// File: rtl/itoc_pkg.sv
`timescale 1ns / 1ps

package itoc_pkg;

    // Operand accumulators hold up to 2^31-1
    localparam int OPERAND_BITS = 31;
    localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = {OPERAND_BITS{1'b1}};

    // One quotient bit per divider step
    localparam int DIV_CNT_BITS = $clog2(OPERAND_BITS);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_OP   = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    // Parser phase
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    // Execution unit state
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_EXEC  = 2'd1,
        BK_DIV   = 2'd2,
        BK_WRITE = 2'd3
    } t_bk_state;

    // One classified expression handed to the execution unit
    typedef struct packed {
        logic                    is_err;
        logic [1:0]              op;
        logic [OPERAND_BITS-1:0] a;
        logic [OPERAND_BITS-1:0] b;
    } t_cmd;

endpackage

// File: rtl/itoc_front.sv
`timescale 1ns / 1ps

module itoc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_char_in,
    output logic             o_stall,
    input  logic             i_q_full,
    output logic             o_push,
    output itoc_pkg::t_cmd   o_cmd
);

    itoc_pkg::t_phase                  r_phase, n_phase;
    logic [itoc_pkg::OPERAND_BITS-1:0] r_first, n_first;
    logic [itoc_pkg::OPERAND_BITS-1:0] r_second, n_second;
    logic [1:0]                        r_op, n_op;

    logic       accept;
    logic       is_digit, is_blank, is_eol, is_op;
    logic [1:0] char_op;
    logic [3:0] digit;

    // Multiply by ten, add the digit, saturate
    function automatic logic [itoc_pkg::OPERAND_BITS-1:0] acc_digit(
        input logic [itoc_pkg::OPERAND_BITS-1:0] acc,
        input logic [3:0]                        d
    );
        logic [itoc_pkg::OPERAND_BITS+3:0] w;
        w = ((itoc_pkg::OPERAND_BITS+4)'(acc) << 3)
          + ((itoc_pkg::OPERAND_BITS+4)'(acc) << 1)
          + (itoc_pkg::OPERAND_BITS+4)'(d);
        if (w > (itoc_pkg::OPERAND_BITS+4)'(itoc_pkg::OPERAND_MAX)) begin
            return itoc_pkg::OPERAND_MAX;
        end
        return w[itoc_pkg::OPERAND_BITS-1:0];
    endfunction

    // Stall whenever the queue has no room
    assign o_stall = i_q_full;
    assign accept  = i_valid & ~i_q_full;

    // Classify the byte
    always_comb begin
        is_digit = i_char_in inside {[itoc_pkg::CH_0:itoc_pkg::CH_9]};
        is_blank = i_char_in inside {itoc_pkg::CH_SPACE, itoc_pkg::CH_TAB};
        is_eol   = i_char_in inside {itoc_pkg::CH_LF, itoc_pkg::CH_NUL};
        digit    = 4'(i_char_in - itoc_pkg::CH_0);
        is_op    = 1'b1;
        case (i_char_in)
            itoc_pkg::CH_PLUS:  char_op = itoc_pkg::OP_ADD;
            itoc_pkg::CH_MINUS: char_op = itoc_pkg::OP_SUB;
            itoc_pkg::CH_STAR:  char_op = itoc_pkg::OP_MUL;
            itoc_pkg::CH_SLASH: char_op = itoc_pkg::OP_DIV;
            default: begin
                char_op = itoc_pkg::OP_ADD;
                is_op   = 1'b0;
            end
        endcase
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                itoc_pkg::PH_SKIP: begin
                    if (is_eol) begin
                        n_phase = itoc_pkg::PH_FIRST;
                    end
                end
                itoc_pkg::PH_SECOND: begin
                    if (!is_blank && !is_digit) begin
                        n_phase = itoc_pkg::PH_FIRST;
                    end
                end
                default: begin
                    if (!is_blank && !is_digit) begin
                        if (is_op) begin
                            n_phase = itoc_pkg::PH_SECOND;
                        end else if (is_eol) begin
                            n_phase = itoc_pkg::PH_FIRST;
                        end else begin
                            n_phase = itoc_pkg::PH_SKIP;
                        end
                    end
                end
            endcase
        end
    end

    // Accumulate operands and issue commands
    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_op     = r_op;
        o_push   = 1'b0;
        o_cmd    = '{is_err: 1'b0, op: r_op, a: r_first, b: r_second};
        if (accept) begin
            case (r_phase)
                itoc_pkg::PH_SKIP: begin
                    // Accumulators are already clear while discarding
                end
                itoc_pkg::PH_SECOND: begin
                    if (is_digit) begin
                        n_second = acc_digit(r_second, digit);
                    end else if (!is_blank) begin
                        o_push   = 1'b1;
                        n_first  = '0;
                        n_second = '0;
                        n_op     = itoc_pkg::OP_ADD;
                    end
                end
                default: begin
                    if (is_digit) begin
                        n_first = acc_digit(r_first, digit);
                    end else if (is_op) begin
                        n_op = char_op;
                    end else if (!is_blank) begin
                        o_push   = 1'b1;
                        o_cmd    = '{is_err: 1'b1, op: itoc_pkg::OP_ADD, a: r_first, b: '0};
                        n_first  = '0;
                        n_second = '0;
                        n_op     = itoc_pkg::OP_ADD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= itoc_pkg::PH_FIRST;
            r_first  <= '0;
            r_second <= '0;
            r_op     <= itoc_pkg::OP_ADD;
        end else begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_op     <= n_op;
        end
    end

endmodule

// File: rtl/itoc_queue.sv
`timescale 1ns / 1ps

module itoc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  itoc_pkg::t_cmd   i_cmd,
    output logic             o_full,
    output logic             o_valid,
    output itoc_pkg::t_cmd   o_cmd,
    input  logic             i_pop
);

    localparam logic [itoc_pkg::QPTR_BITS-1:0] LAST_PTR =
        itoc_pkg::QPTR_BITS'(itoc_pkg::QUEUE_DEPTH - 1);
    localparam logic [itoc_pkg::QCNT_BITS-1:0] FULL_CNT =
        itoc_pkg::QCNT_BITS'(itoc_pkg::QUEUE_DEPTH);

    itoc_pkg::t_cmd                  r_mem [itoc_pkg::QUEUE_DEPTH];
    logic [itoc_pkg::QPTR_BITS-1:0]  r_wptr, n_wptr;
    logic [itoc_pkg::QPTR_BITS-1:0]  r_rptr, n_rptr;
    logic [itoc_pkg::QCNT_BITS-1:0]  r_count, n_count;
    logic                            do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue occupancy above depth");

endmodule

// File: rtl/itoc_back.sv
`timescale 1ns / 1ps

module itoc_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  itoc_pkg::t_cmd                    i_q_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_value,
    output logic [itoc_pkg::OPERAND_BITS-1:0] o_first_operand,
    output logic [itoc_pkg::OPERAND_BITS-1:0] o_second_operand,
    output logic [1:0]                        o_op_code,
    output logic [1:0]                        o_status
);

    localparam int OB = itoc_pkg::OPERAND_BITS;
    localparam logic [itoc_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
        itoc_pkg::DIV_CNT_BITS'(OB - 1);

    itoc_pkg::t_bk_state r_state, n_state;
    itoc_pkg::t_cmd      r_w;

    logic [63:0]                       r_res, n_res;
    logic [1:0]                        r_st, n_st;
    logic [OB-1:0]                     r_rem, n_rem;
    logic [OB-1:0]                     r_quo, n_quo;
    logic [itoc_pkg::DIV_CNT_BITS-1:0] r_cnt, n_cnt;

    logic                              r_out_valid;
    logic signed [31:0]                r_value;
    logic [OB-1:0]                     r_first, r_second;
    logic [1:0]                        r_op, r_status;

    logic                              out_free, load_out, needs_div;
    logic [2*OB-1:0]                   prod;
    logic [OB:0]                       shifted;
    logic [OB+1:0]                     trial;
    logic signed [WORD_BITS-1:0]       wrap_w;
    logic signed [63:0]                wrap_x;

    assign out_free  = ~r_out_valid | ~i_stall;
    assign needs_div = ~r_w.is_err && (r_w.op == itoc_pkg::OP_DIV) && (r_w.b != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itoc_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = itoc_pkg::BK_EXEC;
                end
            end
            itoc_pkg::BK_EXEC: begin
                n_state = needs_div ? itoc_pkg::BK_DIV : itoc_pkg::BK_WRITE;
            end
            itoc_pkg::BK_DIV: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = itoc_pkg::BK_WRITE;
                end
            end
            itoc_pkg::BK_WRITE: begin
                if (out_free) begin
                    n_state = itoc_pkg::BK_IDLE;
                end
            end
            default: n_state = itoc_pkg::BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop    = (r_state == itoc_pkg::BK_IDLE) && i_q_valid;
        load_out = (r_state == itoc_pkg::BK_WRITE) && out_free;
    end

    // Arithmetic datapath
    always_comb begin
        prod    = r_w.a * r_w.b;
        shifted = {r_rem, r_quo[OB-1]};
        trial   = {1'b0, shifted} - {2'b00, r_w.b};
        n_res   = r_res;
        n_st    = r_st;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        case (r_state)
            itoc_pkg::BK_EXEC: begin
                n_st  = itoc_pkg::ST_OK;
                n_res = '0;
                n_rem = '0;
                n_quo = r_w.a;
                n_cnt = '0;
                if (r_w.is_err) begin
                    n_st = itoc_pkg::ST_BAD_OP;
                end else begin
                    case (r_w.op)
                        itoc_pkg::OP_ADD: n_res = 64'(r_w.a) + 64'(r_w.b);
                        itoc_pkg::OP_SUB: n_res = 64'(r_w.a) - 64'(r_w.b);
                        itoc_pkg::OP_MUL: n_res = 64'(prod);
                        default: begin
                            if (r_w.b == '0) begin
                                n_st = itoc_pkg::ST_DIV_ZERO;
                            end
                        end
                    endcase
                end
            end
            itoc_pkg::BK_DIV: begin
                // One restoring step per cycle
                if (trial[OB+1]) begin
                    n_rem = shifted[OB-1:0];
                end else begin
                    n_rem = trial[OB-1:0];
                end
                n_quo = {r_quo[OB-2:0], ~trial[OB+1]};
                n_cnt = r_cnt + 1'b1;
                n_res = 64'(n_quo);
            end
            default: begin
            end
        endcase
    end

    // Wrap to the word size, then sign-extend
    always_comb begin
        wrap_w = r_res[WORD_BITS-1:0];
        wrap_x = 64'(wrap_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itoc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold working operands and results
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_w <= i_q_cmd;
        end
        r_res <= n_res;
        r_st  <= n_st;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        if (load_out) begin
            r_value  <= wrap_x[31:0];
            r_first  <= r_w.a;
            r_second <= r_w.b;
            r_op     <= r_w.op;
            r_status <= r_st;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value          = r_value;
    assign o_first_operand  = r_first;
    assign o_second_operand = r_second;
    assign o_op_code        = r_op;
    assign o_status         = r_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status != itoc_pkg::ST_OK) |-> (r_value == '0))
        else $error("error result with nonzero value");

    a_bad_op_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == itoc_pkg::ST_BAD_OP)
            |-> (r_op == itoc_pkg::OP_ADD) && (r_second == '0))
        else $error("operator error with stray operator or second operand");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itoc_pkg::BK_DIV) |-> needs_div)
        else $error("divider running without a nonzero divisor");

    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_state == itoc_pkg::BK_IDLE) && r_out_valid)
        else $error("result load did not retire the command");

endmodule

// File: rtl/infix_two_operand_calculator_top.sv
`timescale 1ns / 1ps

// Two-operand ASCII calculator: "number operator number" in, one result out.
// Input channel: i_valid / o_stall with one text byte on i_char_in per beat.
// Output channel: o_valid / i_stall with value, both operands, operator code
// and status per beat.
// A parser takes one byte per cycle and hands each finished expression to a
// two-entry command queue; o_stall rises only while that queue is full.
// The execution unit takes one command from the queue at a time and steps
// through pop, compute and write for add, subtract, multiply or an error;
// a division runs the 31-step restoring divider between compute and write.
// The result sits in an output register; while i_stall is high it holds,
// and the parser keeps taking bytes until the queue fills.
// Reset (synchronous, active low) returns the parser to the first number,
// clears both accumulators, empties the queue and drops o_valid.
// WORD_BITS sets the width the result wraps to before sign extension.

module infix_two_operand_calculator_top #(
    parameter int WORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_char_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_value,
    output logic [itoc_pkg::OPERAND_BITS-1:0] o_first_operand,
    output logic [itoc_pkg::OPERAND_BITS-1:0] o_second_operand,
    output logic [1:0]                        o_op_code,
    output logic [1:0]                        o_status
);

    logic           push, q_full, q_valid, pop;
    itoc_pkg::t_cmd push_cmd, q_cmd;

    itoc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_char_in (i_char_in),
        .o_stall   (o_stall),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    itoc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    itoc_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value          (o_value),
        .o_first_operand  (o_first_operand),
        .o_second_operand (o_second_operand),
        .o_op_code        (o_op_code),
        .o_status         (o_status)
    );

endmodule

// File: bench/calc_result_checker.sv
`timescale 1ns / 1ps

module calc_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [7:0]                        i_char,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [31:0]                i_value,
    input  logic [itoc_pkg::OPERAND_BITS-1:0] i_first,
    input  logic [itoc_pkg::OPERAND_BITS-1:0] i_second,
    input  logic [1:0]                        i_op,
    input  logic [1:0]                        i_status,
    output int                                o_error_count,
    output int                                o_pending
);

    typedef struct packed {
        logic [31:0]                       value;
        logic [itoc_pkg::OPERAND_BITS-1:0] first;
        logic [itoc_pkg::OPERAND_BITS-1:0] second;
        logic [1:0]                        op;
        logic [1:0]                        status;
    } t_calc_result;

    // Parser state mirrored beat by beat
    itoc_pkg::t_phase                  expr_phase = itoc_pkg::PH_FIRST;
    logic [itoc_pkg::OPERAND_BITS-1:0] first_acc  = '0;
    logic [itoc_pkg::OPERAND_BITS-1:0] second_acc = '0;
    logic [1:0]                        held_op    = itoc_pkg::OP_ADD;

    t_calc_result result_queue[$];
    int           errors = 0;

    // Shift in one decimal digit, saturating at the operand limit
    function automatic logic [itoc_pkg::OPERAND_BITS-1:0] add_digit(
        input logic [itoc_pkg::OPERAND_BITS-1:0] acc,
        input logic [7:0]                        c
    );
        logic [35:0] sum;
        sum = 36'(acc) * 36'd10 + 36'(c - itoc_pkg::CH_0);
        return (sum > 36'(itoc_pkg::OPERAND_MAX)) ? itoc_pkg::OPERAND_MAX
                                                  : sum[itoc_pkg::OPERAND_BITS-1:0];
    endfunction

    task automatic clear_expr();
        first_acc  = '0;
        second_acc = '0;
        held_op    = itoc_pkg::OP_ADD;
        expr_phase = itoc_pkg::PH_FIRST;
    endtask

    // Advance the parser by one text beat and queue any result it ends
    task automatic parse_char(input logic [7:0] c);
        logic         is_digit;
        logic         is_blank;
        logic         is_eol;
        logic         is_op;
        logic [1:0]   op;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  r;
        t_calc_result res;
        is_digit = (c >= itoc_pkg::CH_0) && (c <= itoc_pkg::CH_9);
        is_blank = (c == itoc_pkg::CH_SPACE) || (c == itoc_pkg::CH_TAB);
        is_eol   = (c == itoc_pkg::CH_LF) || (c == itoc_pkg::CH_NUL);
        is_op    = 1'b1;
        case (c)
            itoc_pkg::CH_PLUS:  op = itoc_pkg::OP_ADD;
            itoc_pkg::CH_MINUS: op = itoc_pkg::OP_SUB;
            itoc_pkg::CH_STAR:  op = itoc_pkg::OP_MUL;
            itoc_pkg::CH_SLASH: op = itoc_pkg::OP_DIV;
            default: begin
                op    = itoc_pkg::OP_ADD;
                is_op = 1'b0;
            end
        endcase
        a   = 64'(first_acc);
        b   = 64'(second_acc);
        r   = '0;
        res = '0;

        if (expr_phase == itoc_pkg::PH_SKIP) begin
            // drop everything up to the end of the line
            if (is_eol) clear_expr();
        end else if (!is_blank) begin
            if (expr_phase == itoc_pkg::PH_SECOND) begin
                if (is_digit) begin
                    second_acc = add_digit(second_acc, c);
                end else begin
                    res.first  = first_acc;
                    res.second = second_acc;
                    res.op     = held_op;
                    res.status = itoc_pkg::ST_OK;
                    case (held_op)
                        itoc_pkg::OP_ADD: r = a + b;
                        itoc_pkg::OP_SUB: r = a - b;
                        itoc_pkg::OP_MUL: r = a * b;
                        default: begin
                            if (b == 64'd0) res.status = itoc_pkg::ST_DIV_ZERO;
                            else r = a / b;
                        end
                    endcase
                    res.value = r[31:0];
                    result_queue.push_back(res);
                    clear_expr();
                end
            end else begin
                // first number; the unused phase code behaves the same way
                if (is_digit) begin
                    first_acc = add_digit(first_acc, c);
                end else if (is_op) begin
                    held_op    = op;
                    expr_phase = itoc_pkg::PH_SECOND;
                end else begin
                    res.first  = first_acc;
                    res.status = itoc_pkg::ST_BAD_OP;
                    result_queue.push_back(res);
                    clear_expr();
                    if (!is_eol) expr_phase = itoc_pkg::PH_SKIP;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        t_calc_result want;
        if (result_queue.size() == 0) begin
            $error("result beat with none pending: value %0h", i_value);
            errors++;
        end else begin
            want = result_queue.pop_front();
            check_field("value", want.value, i_value);
            check_field("first_operand", 32'(want.first), 32'(i_first));
            check_field("second_operand", 32'(want.second), 32'(i_second));
            check_field("op_code", 32'(want.op), 32'(i_op));
            check_field("status", 32'(want.status), 32'(i_status));
        end
    endtask

    // Compare the result beat before taking the text beat: a result always
    // stems from a byte accepted in an earlier cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_expr();
            result_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) parse_char(i_char);
        end
        o_pending     <= result_queue.size();
        o_error_count <= errors;
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_TARGET = 1250;

    // Short directed text: every operator, negative difference, division by
    // zero, truncation, blanks, empty line, bad operator with discard, and
    // an operator with both numbers empty
    localparam logic [7:0] DIRECTED [24] = '{
        8'h37, itoc_pkg::CH_STAR, 8'h36, 8'h3D,
        8'h35, itoc_pkg::CH_MINUS, itoc_pkg::CH_9, itoc_pkg::CH_LF,
        8'h38, itoc_pkg::CH_SLASH, itoc_pkg::CH_0, itoc_pkg::CH_NUL,
        itoc_pkg::CH_9, itoc_pkg::CH_SLASH, itoc_pkg::CH_SPACE, 8'h32,
        itoc_pkg::CH_TAB, itoc_pkg::CH_LF,
        itoc_pkg::CH_LF,
        8'hFF, 8'h61, itoc_pkg::CH_NUL,
        itoc_pkg::CH_PLUS, itoc_pkg::CH_LF
    };

    logic                              i_clk     = 1'b0;
    logic                              i_rst_n   = 1'b0;
    logic                              i_valid   = 1'b0;
    logic [7:0]                        i_char_in = itoc_pkg::CH_NUL;
    logic                              i_stall   = 1'b0;
    logic                              o_stall;
    logic                              o_valid;
    logic signed [31:0]                o_value;
    logic [itoc_pkg::OPERAND_BITS-1:0] o_first_operand;
    logic [itoc_pkg::OPERAND_BITS-1:0] o_second_operand;
    logic [1:0]                        o_op_code;
    logic [1:0]                        o_status;

    int   error_count;
    int   pending;
    int   sent_items = 0;
    logic calm       = 1'b0;
    logic drained    = 1'b0;

    infix_two_operand_calculator_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_in        (i_char_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value          (o_value),
        .o_first_operand  (o_first_operand),
        .o_second_operand (o_second_operand),
        .o_op_code        (o_op_code),
        .o_status         (o_status)
    );

    calc_result_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_char        (i_char_in),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_value       (o_value),
        .i_first       (o_first_operand),
        .i_second      (o_second_operand),
        .i_op          (o_op_code),
        .i_status      (o_status),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // End the run with a failure if the block hangs
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Stall the result side at random, except during the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < 27);
        end
    end

    // Send one text beat, idling at random first
    task automatic send_char(input logic [7:0] c);
        while (!calm && $urandom_range(0, 99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (o_stall);
        sent_items++;
        calm <= (sent_items >= 300) && (sent_items < 480);
    endtask

    // Drop valid and hold until every pending result has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mostly short numbers, some empty, a few long enough to saturate
    function automatic int digit_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) return 0;
        if (roll < 14) return $urandom_range(10, 12);
        return $urandom_range(1, $urandom_range(1, 9));
    endfunction

    // Any byte that is neither a digit nor a blank, and no operator unless allow_op is set
    function automatic logic [7:0] pick_stray(input logic allow_op);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while ((c >= itoc_pkg::CH_0 && c <= itoc_pkg::CH_9) ||
               c == itoc_pkg::CH_SPACE || c == itoc_pkg::CH_TAB ||
               (!allow_op && (c == itoc_pkg::CH_PLUS || c == itoc_pkg::CH_MINUS ||
                              c == itoc_pkg::CH_STAR || c == itoc_pkg::CH_SLASH)));
        return c;
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return itoc_pkg::CH_PLUS;
            1:       return itoc_pkg::CH_MINUS;
            2:       return itoc_pkg::CH_STAR;
            default: return itoc_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_end();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return itoc_pkg::CH_LF;
        if (roll < 50) return itoc_pkg::CH_NUL;
        return pick_stray(1'b1);
    endfunction

    task automatic send_digits(input int count);
        repeat (count) send_char(itoc_pkg::CH_0 + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_blanks();
        if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 2))
                send_char($urandom_range(0, 1) ? itoc_pkg::CH_SPACE : itoc_pkg::CH_TAB);
        end
    endtask

    initial begin
        int kind;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) send_char(DIRECTED[k]);

        while (sent_items < ITEM_TARGET) begin
            // Pause the text once midway until all results are out
            if (!drained && sent_items >= 640) begin
                drain_results();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // well-formed expression with random content
                send_blanks();
                send_digits(digit_count());
                send_blanks();
                send_char(pick_op());
                send_blanks();
                send_digits(digit_count());
                send_blanks();
                send_char(pick_end());
            end else if (kind < 85) begin
                // bad operator, trailing junk, then end of line
                send_digits(digit_count());
                send_char(pick_stray(1'b0));
                repeat ($urandom_range(0, 5)) send_char(8'($urandom_range(0, 255)));
                send_char($urandom_range(0, 3) ? itoc_pkg::CH_LF : itoc_pkg::CH_NUL);
            end else begin
                repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
            end
        end

        drain_results();
        repeat (60) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/itoc_pkg.sv
rtl/itoc_front.sv
rtl/itoc_queue.sv
rtl/itoc_back.sv
rtl/infix_two_operand_calculator_top.sv
bench/calc_result_checker.sv
bench/testbench.sv
